// ===== rtl/lmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and codes of the LED matrix row scan driver.
// ----------------------------------------------------------------------------
package lmrs_pkg;

	// command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_PIXEL = 3'd1;
	localparam logic [2:0] CMD_RAW   = 3'd2;
	localparam logic [2:0] CMD_FILL  = 3'd3;
	localparam logic [2:0] CMD_SWAP  = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_DATA      = 2'd0;
	localparam logic [1:0] STAT_SWAP_OK   = 2'd1;
	localparam logic [1:0] STAT_SWAP_BUSY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ROWS   = 2'd0;
	localparam logic [1:0] REG_ZONES  = 2'd1;
	localparam logic [1:0] REG_LEVEL  = 2'd2;
	localparam logic [1:0] REG_STEPS  = 2'd3;

	// configuration reset values
	localparam logic [3:0] ROWS_RST  = 4'd8;
	localparam logic [4:0] ZONES_RST = 5'd16;
	localparam logic [7:0] LEVEL_RST = 8'd255;
	localparam logic [7:0] STEPS_RST = 8'd1;

	// one result item
	typedef struct packed {
		logic [7:0] shift_byte;
		logic       is_row_select;
		logic       last;
		logic [1:0] status;
	} res_t;

	// output queue occupancy seen by the sequencer
	typedef struct packed {
		logic [1:0] free;
		logic       pop;
	} ofifo_stat_t;

endpackage

// ===== rtl/lmrs_frame_ram.sv =====
// ----------------------------------------------------------------------------
// lmrs_frame_ram
// Single-port frame store holding both frame buffers, registered read.
// ----------------------------------------------------------------------------
module lmrs_frame_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write, or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/lmrs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lmrs_out_fifo
// Two-entry result queue between the scan sequencer and the output channel.
// ----------------------------------------------------------------------------
module lmrs_out_fifo
	import lmrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	input  res_t        push_res,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        out_res,
	output ofifo_stat_t ostat
);

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid  = (cnt_q != 2'd0);
	assign pop        = out_valid && !out_stall;
	assign out_res    = ent_q[rd_q];
	assign ostat.free = 2'd2 - cnt_q;
	assign ostat.pop  = pop;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_valid) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push_valid) - 2'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_valid) begin
			ent_q[wr_q] <= push_res;
		end
	end

endmodule

// ===== rtl/lmrs_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmrs_scan_ctrl
// Command sequencer: configuration, scan state, frame store accesses and
// result generation.
// ----------------------------------------------------------------------------
module lmrs_scan_ctrl
	import lmrs_pkg::*;
#(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_ZONES = 16,
	parameter int BUF       = MAX_ROWS * MAX_ZONES,
	parameter int AW        = $clog2(2 * BUF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write_en,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    command,
	input  logic [7:0]    pixel_x,
	input  logic [3:0]    pixel_y,
	input  logic          pixel_on,
	input  logic [6:0]    byte_address,
	input  logic [7:0]    byte_value,
	output logic          mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata,
	input  logic [7:0]    mem_rdata,
	output logic          push_valid,
	output res_t          push_res,
	input  ofifo_stat_t   ostat
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_TICK   = 3'd2;
	localparam logic [2:0] ST_PIX_RD = 3'd3;
	localparam logic [2:0] ST_PIX_WR = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_SWAP   = 3'd6;

	localparam logic [9:0]    BUF_A     = 10'(BUF);
	localparam logic [AW-1:0] CLEAR_END = AW'(2 * BUF - 1);
	localparam logic [AW-1:0] FILL_END  = AW'(BUF - 1);
	localparam logic [3:0]    MAXR      = 4'(MAX_ROWS);
	localparam logic [5:0]    MAXZ_CMP  = 6'(MAX_ZONES);
	localparam logic [4:0]    MAXZ      = 5'(MAX_ZONES);

	function automatic logic [9:0] buf_addr(input logic bank, input logic [9:0] idx);
		return (bank ? BUF_A : 10'd0) + idx;
	endfunction

	logic [2:0]    state_q;
	logic [3:0]    rows_q;
	logic [4:0]    zones_q;
	logic [7:0]    level_q;
	logic [7:0]    steps_q;
	logic          front_q;
	logic [2:0]    scan_row_q;
	logic [7:0]    bstep_q;
	logic          swap_pend_q;
	logic          swap_done_q;
	logic [AW-1:0] sweep_q;
	logic          s1_v_q;
	logic          s1_rd_q;
	res_t          s1_res_q;
	logic [4:0]    z_q;
	logic          phase_q;
	logic          blank_q;
	logic          on_q;
	logic [AW-1:0] pix_addr_q;
	logic [7:0]    pix_mask_q;
	logic [1:0]    swap_stat_q;

	logic [3:0] eff_rows;
	logic [4:0] eff_zones;
	logic [7:0] eff_steps;
	logic       in_acc;
	logic       can_issue;
	logic [2:0] room;
	logic [8:0] tick_idx;
	logic [9:0] pix_idx;
	logic       pix_ok;
	logic       raw_ok;
	logic       wrap;
	logic [8:0] bstep_inc;
	logic [9:0] mem_full;
	logic       s1_v_d;
	logic       s1_rd_d;
	res_t       s1_res_d;
	logic       tick_end;

	// register limits applied where used
	assign eff_rows  = (rows_q == 4'd0) ? 4'd1 : ((rows_q > MAXR) ? MAXR : rows_q);
	assign eff_zones = (zones_q == 5'd0) ? 5'd1 :
		(({1'b0, zones_q} > MAXZ_CMP) ? MAXZ : zones_q);
	assign eff_steps = (steps_q == 8'd0) ? 8'd1 : steps_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && (state_q == ST_IDLE);

	// room in the output queue once the request in flight lands
	assign room      = 3'(ostat.free) + 3'(ostat.pop);
	assign can_issue = (room > 3'(s1_v_q));

	// address arithmetic
	assign tick_idx = 9'(scan_row_q) * 9'(eff_zones) + 9'(z_q);
	assign pix_idx  = 10'(pixel_y) * 10'(eff_zones) + 10'(pixel_x[7:3]);
	assign pix_ok   = (pixel_y < eff_rows) && (pixel_x < {eff_zones, 3'b000})
		&& (pix_idx < BUF_A);
	assign raw_ok   = (10'(byte_address) < BUF_A);

	assign tick_end  = (state_q == ST_TICK) && can_issue && phase_q;
	assign wrap      = ({1'b0, scan_row_q} + 4'd1) >= eff_rows;
	assign bstep_inc = 9'(bstep_q) + 9'd1;

	// frame store port and next result request
	always_comb begin
		mem_we    = 1'b0;
		mem_full  = buf_addr(front_q, 10'(tick_idx));
		mem_wdata = 8'd0;
		s1_v_d    = 1'b0;
		s1_rd_d   = 1'b0;
		s1_res_d  = '{shift_byte: 8'd0, is_row_select: 1'b0, last: 1'b0,
			status: STAT_DATA};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_full = 10'(sweep_q);
			end
			ST_IDLE: begin
				if (in_acc && (command == CMD_RAW) && raw_ok) begin
					mem_we    = 1'b1;
					mem_full  = buf_addr(!front_q, 10'(byte_address));
					mem_wdata = byte_value;
				end
			end
			ST_TICK: begin
				if (can_issue) begin
					s1_v_d = 1'b1;
					if (phase_q) begin
						s1_res_d.shift_byte    = 8'd1 << scan_row_q;
						s1_res_d.is_row_select = 1'b1;
						s1_res_d.last          = 1'b1;
					end else if (!blank_q && ({1'b0, tick_idx} < BUF_A)) begin
						s1_rd_d = 1'b1;
					end
				end
			end
			ST_PIX_RD: begin
				mem_full = 10'(pix_addr_q);
			end
			ST_PIX_WR: begin
				mem_we    = 1'b1;
				mem_full  = 10'(pix_addr_q);
				mem_wdata = on_q ? (mem_rdata | pix_mask_q) : (mem_rdata & ~pix_mask_q);
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_full  = buf_addr(!front_q, 10'(sweep_q));
				mem_wdata = on_q ? 8'hFF : 8'h00;
			end
			ST_SWAP: begin
				if (can_issue) begin
					s1_v_d          = 1'b1;
					s1_res_d.last   = 1'b1;
					s1_res_d.status = swap_stat_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_addr = mem_full[AW-1:0];

	// result leaves in the cycle after its request, with read data merged in
	assign push_valid          = s1_v_q;
	assign push_res.shift_byte = s1_rd_q ? mem_rdata : s1_res_q.shift_byte;
	assign push_res.is_row_select = s1_res_q.is_row_select;
	assign push_res.last       = s1_res_q.last;
	assign push_res.status     = s1_res_q.status;

	// control state, scan state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			rows_q      <= ROWS_RST;
			zones_q     <= ZONES_RST;
			level_q     <= LEVEL_RST;
			steps_q     <= STEPS_RST;
			front_q     <= 1'b0;
			scan_row_q  <= 3'd0;
			bstep_q     <= 8'd0;
			swap_pend_q <= 1'b0;
			swap_done_q <= 1'b1;
			s1_v_q      <= 1'b0;
			s1_rd_q     <= 1'b0;
		end else begin
			s1_v_q  <= s1_v_d;
			s1_rd_q <= s1_rd_d;
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == CLEAR_END) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (command)
							CMD_TICK: state_q <= ST_TICK;
							CMD_PIXEL: begin
								if (pix_ok) begin
									state_q <= ST_PIX_RD;
								end
							end
							CMD_FILL: begin
								sweep_q <= '0;
								state_q <= ST_FILL;
							end
							CMD_SWAP: begin
								if (swap_done_q) begin
									swap_done_q <= 1'b0;
									swap_pend_q <= 1'b1;
								end
								state_q <= ST_SWAP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TICK: begin
					if (tick_end) begin
						state_q <= ST_IDLE;
						if (wrap) begin
							scan_row_q <= 3'd0;
							if (swap_pend_q) begin
								front_q     <= ~front_q;
								swap_pend_q <= 1'b0;
								swap_done_q <= 1'b1;
							end
							bstep_q <= (bstep_inc >= 9'(eff_steps)) ? 8'd0 : bstep_inc[7:0];
						end else begin
							scan_row_q <= scan_row_q + 3'd1;
						end
					end
				end
				ST_PIX_RD: state_q <= ST_PIX_WR;
				ST_PIX_WR: state_q <= ST_IDLE;
				ST_FILL: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == FILL_END) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWAP: begin
					if (can_issue) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// register writes
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_ROWS:  rows_q  <= cfg_data[3:0];
					REG_ZONES: zones_q <= cfg_data[4:0];
					REG_LEVEL: level_q <= cfg_data;
					REG_STEPS: begin
						steps_q <= cfg_data;
						bstep_q <= 8'd0;
					end
					default: rows_q <= rows_q;
				endcase
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		s1_res_q <= s1_res_d;
		if (in_acc) begin
			z_q         <= eff_zones - 5'd1;
			phase_q     <= 1'b0;
			blank_q     <= (bstep_q > level_q);
			on_q        <= pixel_on;
			pix_addr_q  <= AW'(buf_addr(!front_q, pix_idx));
			pix_mask_q  <= 8'd1 << pixel_x[2:0];
			swap_stat_q <= swap_done_q ? STAT_SWAP_OK : STAT_SWAP_BUSY;
		end else if ((state_q == ST_TICK) && can_issue && !phase_q) begin
			if (z_q == 5'd0) begin
				phase_q <= 1'b1;
			end else begin
				z_q <= z_q - 5'd1;
			end
		end
	end

endmodule

// ===== rtl/led_matrix_row_scan_driver.sv =====
// ----------------------------------------------------------------------------
// led_matrix_row_scan_driver
// Double-buffered, row-multiplexed monochrome LED matrix scan driver.
// ----------------------------------------------------------------------------
// Both frame buffers live in one single-port RAM of 2*MAX_ROWS*MAX_ZONES
// bytes; writes go to the back buffer, scans read the front one. After reset
// a clearing pass zeroes all 2*MAX_ROWS*MAX_ZONES bytes of the RAM
// with input held off; configuration writes are taken meanwhile.
// Commands are handled one at a time. A tick takes acceptance, then one zone
// byte per cycle from the RAM port while the output queue has room, for the
// zones in use (limited to 1..MAX_ZONES), then the row select byte; a set
// pixel is read, modified and written back on the one port; a raw byte write
// is a single RAM write; a fill does one RAM write per byte of the back
// buffer; a swap request yields one status result. A two-entry output queue
// lets results wait while the next request is accepted; once it is full, a
// stalled output holds the tick or swap in progress.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver
	import lmrs_pkg::*;
#(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_ZONES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] pixel_x,
	input  logic [3:0] pixel_y,
	input  logic       pixel_on,
	input  logic [6:0] byte_address,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] shift_byte,
	output logic       is_row_select,
	output logic       last,
	output logic [1:0] status
);

	localparam int BUF = MAX_ROWS * MAX_ZONES;
	localparam int AW  = $clog2(2 * BUF);

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic          push_valid;
	res_t          push_res;
	res_t          out_res;
	ofifo_stat_t   ostat;

	// sequencer
	lmrs_scan_ctrl #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_ZONES (MAX_ZONES),
		.BUF       (BUF),
		.AW        (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_on     (pixel_on),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.mem_we       (mem_we),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata),
		.push_valid   (push_valid),
		.push_res     (push_res),
		.ostat        (ostat)
	);

	// frame store
	lmrs_frame_ram #(
		.DEPTH (2 * BUF),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// output queue
	lmrs_out_fifo u_ofifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_res   (push_res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res),
		.ostat      (ostat)
	);

	assign shift_byte    = out_res.shift_byte;
	assign is_row_select = out_res.is_row_select;
	assign last          = out_res.last;
	assign status        = out_res.status;

endmodule
